### design/lis_pkg.sv
package lis_pkg;

  localparam int MAX_ITEMS    = 64;
  localparam int STEP_BITS    = 10;
  localparam int IDX_W        = $clog2(MAX_ITEMS);
  localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
  localparam int ITEM_INDEX_W = 6;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [STEP_BITS-1:0] start_step;
    logic [STEP_BITS-1:0] end_step;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Signed span end - start; the +1 of the lifetime cancels in a comparison.
  function automatic logic signed [STEP_BITS:0] span_of(entry_t e);
    span_of = $signed({1'b0, e.end_step}) - $signed({1'b0, e.start_step});
  endfunction

endpackage

### design/lis_ram.sv
module lis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/lis_cmp.sv
// Compare-and-exchange unit: the lower entry is written back, the higher travels on.
module lis_cmp (
  input  lis_pkg::entry_t a_i,
  input  lis_pkg::entry_t b_i,
  output lis_pkg::entry_t low_o,
  output lis_pkg::entry_t high_o
);

  logic signed [lis_pkg::STEP_BITS:0] span_a;
  logic signed [lis_pkg::STEP_BITS:0] span_b;
  logic                               a_after;

  assign span_a = lis_pkg::span_of(a_i);
  assign span_b = lis_pkg::span_of(b_i);

  always_comb begin
    if (span_a != span_b) begin
      a_after = span_a > span_b;
    end else begin
      a_after = a_i.start_step > b_i.start_step;
    end
  end

  assign low_o  = a_after ? b_i : a_i;
  assign high_o = a_after ? a_i : b_i;

endmodule

### design/lifetime_interval_sorter.sv
// Live-interval sorter.
// Intervals are loaded one request at a time: a request is taken at a rising edge with
// start_i high and busy_o low, and carries start_step_i, end_step_i and is_last_i.
// A load without is_last_i leaves the block idle, ready for the next request.
// Requests beyond the store capacity are not kept; they mark the set as overflowed.
// The request with is_last_i set starts the sort, ordering the set by ascending
// lifetime (end - start + 1, signed), then by smaller start, keeping arrival order
// for equal keys. busy_o stays high until the whole set has been delivered.
// Sorting of n entries is a bubble sort through one comparator and the single
// read and write port of the interval store. Delivery then follows, with one
// result per cycle in index order of the sorted store.
// Each result appears for exactly one cycle with valid_o high; last_out_o marks the
// final one and overflow_o is the same on every result of a set. The receiver cannot
// stall, so results are never held. Reset clears the count and the overflow mark and
// returns the block to idle; the store itself is not cleared and needs no sweep.
module lifetime_interval_sorter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [lis_pkg::STEP_BITS-1:0]       start_step_i,
  input  logic [lis_pkg::STEP_BITS-1:0]       end_step_i,
  input  logic                                is_last_i,
  output logic                                valid_o,
  output logic [lis_pkg::ITEM_INDEX_W-1:0]    item_index_o,
  output logic [lis_pkg::STEP_BITS-1:0]       out_start_o,
  output logic [lis_pkg::STEP_BITS-1:0]       out_end_o,
  output logic                                overflow_o,
  output logic                                last_out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS_START,
    S_PASS_LOAD,
    S_COMPARE,
    S_PASS_END,
    S_EMIT,
    S_DONE
  } state_e;

  state_e                      state_q;
  logic [lis_pkg::CNT_W-1:0]   count_q;
  logic                        dropped_q;
  logic [lis_pkg::IDX_W-1:0]   k_q;
  logic [lis_pkg::IDX_W-1:0]   bound_q;
  logic [lis_pkg::IDX_W-1:0]   nm1_q;
  logic                        valid_q;
  logic                        lastflag_q;
  lis_pkg::entry_t             carry_q;

  logic                        accept;
  logic                        has_room;
  logic [lis_pkg::CNT_W-1:0]   count_d;

  logic                        ram_we;
  logic [lis_pkg::IDX_W-1:0]   ram_waddr;
  lis_pkg::entry_t             ram_wdata;
  logic [lis_pkg::IDX_W-1:0]   ram_raddr;
  lis_pkg::entry_t             ram_rdata;
  logic [lis_pkg::ENTRY_W-1:0] ram_rdata_raw;

  lis_pkg::entry_t             cmp_low;
  lis_pkg::entry_t             cmp_high;
  lis_pkg::entry_t             load_entry;

  assign accept   = start_i && (state_q == S_IDLE);
  assign has_room = count_q < lis_pkg::CNT_W'(lis_pkg::MAX_ITEMS);
  assign count_d  = has_room ? count_q + lis_pkg::CNT_W'(1) : count_q;

  always_comb begin
    load_entry.idx        = count_q[lis_pkg::IDX_W-1:0];
    load_entry.start_step = start_step_i;
    load_entry.end_step   = end_step_i;
  end

  // Store port steering: loads, write-back of the lower entry, the end of a pass, and the reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[lis_pkg::IDX_W-1:0];
    ram_wdata = load_entry;
    ram_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        ram_we = accept && has_room;
      end
      S_PASS_START: begin
        ram_raddr = '0;
      end
      S_PASS_LOAD: begin
        ram_raddr = lis_pkg::IDX_W'(1);
      end
      S_COMPARE: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = cmp_low;
        ram_raddr = k_q + lis_pkg::IDX_W'(2);
      end
      S_PASS_END: begin
        ram_we    = 1'b1;
        ram_waddr = bound_q;
        ram_wdata = carry_q;
      end
      S_EMIT: begin
        ram_raddr = k_q;
      end
      S_DONE: begin
        ram_raddr = '0;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  lis_ram #(
    .WIDTH (lis_pkg::ENTRY_W),
    .DEPTH (lis_pkg::MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = lis_pkg::entry_t'(ram_rdata_raw);

  // The carried entry is the largest seen so far in this pass.
  lis_cmp u_cmp (
    .a_i    (carry_q),
    .b_i    (ram_rdata),
    .low_o  (cmp_low),
    .high_o (cmp_high)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      k_q        <= '0;
      bound_q    <= '0;
      nm1_q      <= '0;
      valid_q    <= 1'b0;
      lastflag_q <= 1'b0;
      carry_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            if (!has_room) begin
              dropped_q <= 1'b1;
            end
            if (is_last_i) begin
              // The set always holds at least one entry once the final request is in.
              nm1_q   <= lis_pkg::IDX_W'(count_d - lis_pkg::CNT_W'(1));
              bound_q <= lis_pkg::IDX_W'(count_d - lis_pkg::CNT_W'(1));
              k_q     <= '0;
              if (count_d > lis_pkg::CNT_W'(1)) begin
                state_q <= S_PASS_START;
              end else begin
                state_q <= S_EMIT;
              end
            end
          end
        end
        S_PASS_START: begin
          state_q <= S_PASS_LOAD;
        end
        S_PASS_LOAD: begin
          carry_q <= ram_rdata;
          k_q     <= '0;
          state_q <= S_COMPARE;
        end
        S_COMPARE: begin
          carry_q <= cmp_high;
          k_q     <= k_q + lis_pkg::IDX_W'(1);
          if (k_q == bound_q - lis_pkg::IDX_W'(1)) begin
            state_q <= S_PASS_END;
          end
        end
        S_PASS_END: begin
          bound_q <= bound_q - lis_pkg::IDX_W'(1);
          k_q     <= '0;
          if (bound_q == lis_pkg::IDX_W'(1)) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_PASS_START;
          end
        end
        S_EMIT: begin
          // Read data lands in the next cycle, together with the strobe.
          valid_q    <= 1'b1;
          lastflag_q <= (k_q == nm1_q);
          if (k_q == nm1_q) begin
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + lis_pkg::IDX_W'(1);
          end
        end
        S_DONE: begin
          count_q   <= '0;
          dropped_q <= 1'b0;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign item_index_o = lis_pkg::ITEM_INDEX_W'(ram_rdata.idx);
  assign out_start_o  = ram_rdata.start_step;
  assign out_end_o    = ram_rdata.end_step;
  assign overflow_o   = dropped_q;
  assign last_out_o   = valid_q && lastflag_q;

endmodule

### design/lis_checker.sv
module lis_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic is_last_i,
  input logic valid_o,
  input logic last_out_o
);

  // Results are only delivered while the block reports itself busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy_o)
    else $error("result strobe while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni) last_out_o |-> valid_o)
    else $error("final flag without a result");

  // Nothing follows the final result of a set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_out_o) |=> !valid_o)
    else $error("result after the final one");

  // A load that does not close the set leaves the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !is_last_i) |=> !busy_o)
    else $error("plain load made the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && is_last_i) |=> busy_o)
    else $error("final load did not start the sort");

endmodule

bind lifetime_interval_sorter lis_checker u_lis_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .is_last_i  (is_last_i),
  .valid_o    (valid_o),
  .last_out_o (last_out_o)
);
